// File: hw/rtl/assert_macros.svh
// Assertion helpers for RTL that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define ZFW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that an expression is never true while reset is released.
`define ZFW_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/zfw_pkg.sv
// ----------------------------------------------------------------------------
// zfw_pkg
// Types, codes and constants of the forward-warp frame store.
// ----------------------------------------------------------------------------
package zfw_pkg;

	localparam int MAX_WIDTH_DEF = 512;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int COORD_FRAC_BITS_DEF = 4;

	localparam int ACT_W = 2;
	localparam int COORD_W = 16;
	localparam int COLOR_W = 24;
	localparam int DISP_W = 8;
	localparam int ROW_W = 8;
	localparam int COL_W = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int FW_W = 10;
	localparam int FH_W = 9;
	localparam int PIX_W = COLOR_W + DISP_W;

	localparam int LANES = 4;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int NB_COUNT = 9;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_SPLAT = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILL = 2'd0,
		REG_WIDTH = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [DISP_W-1:0] disp;
	} pix_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
	} nb_t;

	function automatic nb_t nb_off(input logic [CNT_W-1:0] k);
		nb_t r;
		unique case (k)
			4'd0: r = '{row: 2'd0, col: 2'd0};
			4'd1: r = '{row: 2'd0, col: 2'd1};
			4'd2: r = '{row: 2'd0, col: 2'd2};
			4'd3: r = '{row: 2'd1, col: 2'd0};
			4'd4: r = '{row: 2'd1, col: 2'd1};
			4'd5: r = '{row: 2'd1, col: 2'd2};
			4'd6: r = '{row: 2'd2, col: 2'd0};
			4'd7: r = '{row: 2'd2, col: 2'd1};
			4'd8: r = '{row: 2'd2, col: 2'd2};
			default: r = '{row: 2'd1, col: 2'd1};
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/zfw_if.sv
// ----------------------------------------------------------------------------
// zfw_if
// Valid/ready channels of the forward-warp frame store.
// ----------------------------------------------------------------------------
interface zfw_in_if import zfw_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	logic signed [COORD_W-1:0] proj_x;
	logic signed [COORD_W-1:0] proj_y;
	logic signed [COORD_W-1:0] right_x;
	logic signed [COORD_W-1:0] left_x;
	logic signed [COORD_W-1:0] below_y;
	logic signed [COORD_W-1:0] above_y;
	logic [COLOR_W-1:0] pixel_color;
	logic [DISP_W-1:0] pixel_disparity;
	logic masked;
	logic [ROW_W-1:0] read_row;
	logic [COL_W-1:0] read_col;
	modport source(output valid, action, proj_x, proj_y, right_x, left_x, below_y, above_y,
		pixel_color, pixel_disparity, masked, read_row, read_col, input ready);
	modport sink(input valid, action, proj_x, proj_y, right_x, left_x, below_y, above_y,
		pixel_color, pixel_disparity, masked, read_row, read_col, output ready);
endinterface

interface zfw_out_if import zfw_pkg::*; ();
	logic valid;
	logic ready;
	logic [COLOR_W-1:0] out_color;
	logic [DISP_W-1:0] out_disparity;
	modport source(output valid, out_color, out_disparity, input ready);
	modport sink(input valid, out_color, out_disparity, output ready);
endinterface

interface zfw_cfg_if import zfw_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/zfw_ram.sv
// ----------------------------------------------------------------------------
// zfw_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module zfw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic we,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: hw/rtl/zfw_div.sv
// ----------------------------------------------------------------------------
// zfw_div
// Four-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module zfw_div import zfw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [CNT_W-1:0] divisor,
	input logic [LANES-1:0][SUM_W-1:0] num,
	output logic done,
	output logic [LANES-1:0][SUM_W-1:0] quot
);
	logic [LANES-1:0][SUM_W-1:0] num_q;
	logic [LANES-1:0][CNT_W-1:0] rem_q;
	logic [LANES-1:0][SUM_W-1:0] num_d;
	logic [LANES-1:0][CNT_W-1:0] rem_d;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] step_q;
	logic busy_q;
	logic done_q;

	always_comb begin
		logic [CNT_W:0] t;
		for (int i = 0; i < LANES; i++) begin
			t = {rem_q[i], num_q[i][SUM_W-1]};
			if (t >= {1'b0, div_q}) begin
				rem_d[i] = CNT_W'(t - {1'b0, div_q});
				num_d[i] = {num_q[i][SUM_W-2:0], 1'b1};
			end else begin
				rem_d[i] = t[CNT_W-1:0];
				num_d[i] = {num_q[i][SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + CNT_W'(1);
			if (step_q == CNT_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

// File: hw/rtl/zbuffer_forward_warp_hole_fill.sv
// ----------------------------------------------------------------------------
// zbuffer_forward_warp_hole_fill
// Forward-warp splatting into a z-buffered frame store with hole fill.
// ----------------------------------------------------------------------------
// Colour and disparity share one single-port RAM of MAX_WIDTH*MAX_HEIGHT words,
// and one item is worked at a time. After reset and after each clear item the
// RAM is swept to zero, one word a cycle, and no item is taken meanwhile. A
// masked or out-of-frame splat is dropped as it is taken; any other splat reads
// its RAM word and writes it if the pixel wins the depth test, then, when fill
// is on and it won, makes the spread writes. A read outside the frame gives
// zero; a read that looks at the 3x3 neighborhood and averages it makes nine
// RAM reads through the one port and twelve divider steps. A read also waits
// in its output state while the previous result is not taken.
`include "assert_macros.svh"

module zbuffer_forward_warp_hole_fill import zfw_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	zfw_in_if.sink in_ch,
	zfw_out_if.source out_ch,
	zfw_cfg_if.sink cfg
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int CW0 = ((XW > YW) ? XW : YW) + COORD_FRAC_BITS + 2;
	localparam int CW = (CW0 > 18) ? CW0 : 18;
	localparam logic signed [CW-1:0] ONE_S = CW'(1 << COORD_FRAC_BITS);
	localparam logic signed [CW-1:0] HALF_S = CW'((1 << COORD_FRAC_BITS) / 2);

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_SPL_RD  = 11'b000_0000_0100,
		ST_SPL_CHK = 11'b000_0000_1000,
		ST_SPL_SPR = 11'b000_0001_0000,
		ST_RD_C    = 11'b000_0010_0000,
		ST_RD_CHK  = 11'b000_0100_0000,
		ST_RD_NB   = 11'b000_1000_0000,
		ST_DIV_ST  = 11'b001_0000_0000,
		ST_DIV     = 11'b010_0000_0000,
		ST_OUT     = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic v;
		logic signed [1:0] dx;
		logic signed [1:0] dy;
	} spread_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic fill_q;
	logic [FW_W-1:0] width_q;
	logic [FH_W-1:0] height_q;
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;

	logic [XW-1:0] sx_q;
	logic [YW-1:0] sy_q;
	pix_t spix_q;
	spread_t [2:0] sp_q;
	logic [1:0] sp_i_q;

	logic [ROW_W-1:0] rr_q;
	logic [COL_W-1:0] rc_q;
	pix_t ctr_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LANES-1:0][SUM_W-1:0] sum_q;
	pix_t res_q;

	logic out_valid_q;
	pix_t out_q;

	logic [AW-1:0] mem_addr;
	logic mem_we;
	pix_t mem_wdata;
	pix_t mem_rdata;

	logic div_done;
	logic [LANES-1:0][SUM_W-1:0] div_quot;

	logic in_acc;
	logic signed [CW-1:0] psx, psy, upx, upy, fx, fy;
	logic signed [CW-1:0] xr, yr;
	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	logic inb, gr, gl, gd, gu;
	spread_t [2:0] sp_new;
	logic read_out;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic spr_ok;
	logic interior;
	nb_t nb;
	logic wr_state;

	function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
		return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
	endfunction

	always_comb begin
		if (16'(width_q) < 16'd3) begin
			w_eff = XW'(3);
		end else if (16'(width_q) > 16'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		if (16'(height_q) < 16'd3) begin
			h_eff = YW'(3);
		end else if (16'(height_q) > 16'(MAX_HEIGHT)) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(height_q);
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		psx = CW'(in_ch.proj_x);
		psy = CW'(in_ch.proj_y);
		upx = signed'(CW'(w_eff - XW'(1))) <<< COORD_FRAC_BITS;
		upy = signed'(CW'(h_eff - YW'(1))) <<< COORD_FRAC_BITS;
		inb = (psx >= ONE_S) && (psx < upx) && (psy >= ONE_S) && (psy < upy);
		xr = (psx + HALF_S) >>> COORD_FRAC_BITS;
		yr = (psy + HALF_S) >>> COORD_FRAC_BITS;
		ax = xr[XW-1:0];
		ay = yr[YW-1:0];
		fx = signed'(CW'(ax)) <<< COORD_FRAC_BITS;
		fy = signed'(CW'(ay)) <<< COORD_FRAC_BITS;
		gr = (CW'(in_ch.right_x) - fx) > ONE_S;
		gl = (CW'(in_ch.left_x) - fx) < -ONE_S;
		gd = (CW'(in_ch.below_y) - fy) > ONE_S;
		gu = (CW'(in_ch.above_y) - fy) < -ONE_S;
		sp_new = '0;
		priority if (gd && gr) begin
			sp_new[0] = '{v: 1'b1, dx: 2'sd1, dy: 2'sd0};
			sp_new[1] = '{v: 1'b1, dx: 2'sd0, dy: 2'sd1};
			sp_new[2] = '{v: 1'b1, dx: 2'sd1, dy: 2'sd1};
		end else if (gu && gl) begin
			sp_new[0] = '{v: 1'b1, dx: -2'sd1, dy: 2'sd0};
			sp_new[1] = '{v: 1'b1, dx: 2'sd0, dy: -2'sd1};
			sp_new[2] = '{v: 1'b1, dx: -2'sd1, dy: -2'sd1};
		end else if (gr) begin
			sp_new[0] = '{v: 1'b1, dx: 2'sd1, dy: 2'sd0};
		end else if (gl) begin
			sp_new[0] = '{v: 1'b1, dx: -2'sd1, dy: 2'sd0};
		end else if (gd) begin
			sp_new[0] = '{v: 1'b1, dx: 2'sd0, dy: 2'sd1};
		end else if (gu) begin
			sp_new[0] = '{v: 1'b1, dx: 2'sd0, dy: -2'sd1};
		end else begin
			sp_new = '0;
		end
		read_out = (16'(in_ch.read_col) >= 16'(w_eff)) || (16'(in_ch.read_row) >= 16'(h_eff));
	end

	always_comb begin
		nx = sx_q + XW'(sp_q[sp_i_q].dx);
		ny = sy_q + YW'(sp_q[sp_i_q].dy);
		spr_ok = sp_q[sp_i_q].v && (nx < w_eff) && (ny < h_eff);
		interior = (rr_q != '0) && (16'(rr_q) < 16'(h_eff - YW'(1)))
			&& (rc_q != '0) && (16'(rc_q) < 16'(w_eff - XW'(1)));
		nb = nb_off(k_q);
	end

	always_comb begin
		mem_addr = addr_of(sy_q, sx_q);
		mem_we = 1'b0;
		mem_wdata = spix_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_q;
				mem_we = 1'b1;
				mem_wdata = '0;
			end
			ST_SPL_CHK: begin
				mem_we = (mem_rdata.disp < spix_q.disp);
			end
			ST_SPL_SPR: begin
				mem_addr = addr_of(ny, nx);
				mem_we = spr_ok;
			end
			ST_RD_C: begin
				mem_addr = addr_of(YW'(rr_q), XW'(rc_q));
			end
			ST_RD_NB: begin
				mem_addr = addr_of(YW'(rr_q) + YW'(nb.row) - YW'(1),
					XW'(rc_q) + XW'(nb.col) - XW'(1));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	zfw_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.addr(mem_addr),
		.we(mem_we),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	zfw_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start((state_q == ST_DIV_ST) && (cnt_q != '0)),
		.divisor(cnt_q),
		.num(sum_q),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b1;
			width_q <= FW_W'(512);
			height_q <= FH_W'(256);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FILL: fill_q <= cfg.data[0];
				REG_WIDTH: width_q <= cfg.data[FW_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[FH_W-1:0];
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sp_i_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.action)
							ACT_CLEAR: begin
								clr_q <= '0;
								state_q <= ST_CLEAR;
							end
							ACT_SPLAT: begin
								if (!in_ch.masked && inb) begin
									state_q <= ST_SPL_RD;
								end
							end
							ACT_READ: begin
								state_q <= read_out ? ST_OUT : ST_RD_C;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SPL_RD: state_q <= ST_SPL_CHK;
				ST_SPL_CHK: begin
					sp_i_q <= '0;
					state_q <= ((mem_rdata.disp < spix_q.disp) && fill_q) ? ST_SPL_SPR : ST_IDLE;
				end
				ST_SPL_SPR: begin
					sp_i_q <= sp_i_q + 2'd1;
					if (sp_i_q == 2'd2) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_C: state_q <= ST_RD_CHK;
				ST_RD_CHK: begin
					k_q <= '0;
					if (fill_q && (mem_rdata.disp == '0) && interior) begin
						state_q <= ST_RD_NB;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_RD_NB: begin
					k_q <= k_q + CNT_W'(1);
					if (k_q == CNT_W'(NB_COUNT)) begin
						state_q <= ST_DIV_ST;
					end
				end
				ST_DIV_ST: state_q <= (cnt_q != '0) ? ST_DIV : ST_OUT;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sx_q <= ax;
			sy_q <= ay;
			spix_q <= '{color: in_ch.pixel_color, disp: in_ch.pixel_disparity};
			sp_q <= sp_new;
			rr_q <= in_ch.read_row;
			rc_q <= in_ch.read_col;
			res_q <= '0;
		end
		if (state_q == ST_RD_CHK) begin
			ctr_q <= mem_rdata;
			res_q <= mem_rdata;
			cnt_q <= '0;
			sum_q <= '0;
		end
		if ((state_q == ST_RD_NB) && (k_q != '0) && (mem_rdata.disp != '0)) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sum_q[0] <= sum_q[0] + SUM_W'(mem_rdata.disp);
			sum_q[1] <= sum_q[1] + SUM_W'(mem_rdata.color[7:0]);
			sum_q[2] <= sum_q[2] + SUM_W'(mem_rdata.color[15:8]);
			sum_q[3] <= sum_q[3] + SUM_W'(mem_rdata.color[23:16]);
		end
		if ((state_q == ST_DIV_ST) && (cnt_q == '0)) begin
			res_q <= ctr_q;
		end
		if ((state_q == ST_DIV) && div_done) begin
			res_q <= '{color: {div_quot[3][7:0], div_quot[2][7:0], div_quot[1][7:0]},
				disp: div_quot[0][7:0]};
		end
		if ((state_q == ST_OUT) && (!out_valid_q || out_ch.ready)) begin
			out_q <= res_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_color = out_q.color;
	assign out_ch.out_disparity = out_q.disp;

	assign wr_state = (state_q == ST_CLEAR) || (state_q == ST_SPL_CHK) || (state_q == ST_SPL_SPR);

	`ZFW_ASSERT(a_we_states, mem_we |-> wr_state, "RAM written outside a write state")
	`ZFW_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result shown without a finished read")
	`ZFW_NEVER(a_div_done_state, div_done && (state_q != ST_DIV), "divider finished outside its wait state")
endmodule
